// ----- rtl/tss_pkg.sv -----
`default_nettype none

package tss_pkg;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 16;

   // register reset values
   localparam int          AdcThresholdReset   = 450;
   localparam logic [7:0]  DutyHighReset       = 8'd204;
   localparam logic [7:0]  DutyLowReset        = 8'd77;
   localparam logic [7:0]  SampleIntervalReset = 8'd50;
   localparam logic [15:0] SequencePeriodReset = 16'd250;
   localparam logic [15:0] HazardPeriodReset   = 16'd500;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_ADC_THRESHOLD   = 3'd0,
      CSR_DUTY_HIGH       = 3'd1,
      CSR_DUTY_LOW        = 3'd2,
      CSR_SAMPLE_INTERVAL = 3'd3,
      CSR_SEQUENCE_PERIOD = 3'd4,
      CSR_HAZARD_PERIOD   = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_LEFT   = 2'd1,
      MODE_RIGHT  = 2'd2,
      MODE_HAZARD = 2'd3
   } mode_type;

   // everything but the threshold, whose width follows the adc
   typedef struct packed {
      logic [7:0]  duty_high;
      logic [7:0]  duty_low;
      logic [7:0]  sample_interval;
      logic [15:0] sequence_period;
      logic [15:0] hazard_period;
   } cfg_type;

   typedef struct packed {
      logic [2:0] left_leds;
      logic [2:0] right_leds;
      logic [7:0] pwm_duty;
   } result_type;

endpackage

`default_nettype wire

// ----- rtl/tss_intf.sv -----
`default_nettype none

interface tss_req_intf #(parameter int ADC_WIDTH = 10);
   logic                 valid;
   logic                 ready;
   logic                 hazard_btn_n;
   logic                 left_btn_n;
   logic                 right_btn_n;
   logic [ADC_WIDTH-1:0] light_sample;

   modport source (output valid, hazard_btn_n, left_btn_n, right_btn_n, light_sample,
                   input ready);
   modport sink   (input valid, hazard_btn_n, left_btn_n, right_btn_n, light_sample,
                   output ready);
endinterface

interface tss_rsp_intf;
   logic       valid;
   logic       ready;
   logic [2:0] left_leds;
   logic [2:0] right_leds;
   logic [7:0] pwm_duty;

   modport source (output valid, left_leds, right_leds, pwm_duty, input ready);
   modport sink   (input valid, left_leds, right_leds, pwm_duty, output ready);
endinterface

interface tss_csr_intf;
   import tss_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [CsrIndexWidth-1:0] index;
   logic [CsrDataWidth-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/tss_csr.sv -----
`default_nettype none

module tss_csr import tss_pkg::*; #(
   parameter int ADC_WIDTH = 10
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     wr_en,
   input  wire logic [CsrIndexWidth-1:0] wr_index,
   input  wire logic [CsrDataWidth-1:0]  wr_data,
   output logic      [ADC_WIDTH-1:0]     adc_threshold,
   output cfg_type                       cfg
);

   localparam logic [ADC_WIDTH-1:0] ThresholdReset = ADC_WIDTH'(AdcThresholdReset);

   logic [ADC_WIDTH-1:0] threshold_ff;
   cfg_type              cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff           <= ThresholdReset;
         cfg_ff.duty_high       <= DutyHighReset;
         cfg_ff.duty_low        <= DutyLowReset;
         cfg_ff.sample_interval <= SampleIntervalReset;
         cfg_ff.sequence_period <= SequencePeriodReset;
         cfg_ff.hazard_period   <= HazardPeriodReset;
      end else if (wr_en) begin
         unique case (csr_index_type'(wr_index))
            CSR_ADC_THRESHOLD:   threshold_ff           <= wr_data[ADC_WIDTH-1:0];
            CSR_DUTY_HIGH:       cfg_ff.duty_high       <= wr_data[7:0];
            CSR_DUTY_LOW:        cfg_ff.duty_low        <= wr_data[7:0];
            CSR_SAMPLE_INTERVAL: cfg_ff.sample_interval <= wr_data[7:0];
            CSR_SEQUENCE_PERIOD: cfg_ff.sequence_period <= wr_data[15:0];
            CSR_HAZARD_PERIOD:   cfg_ff.hazard_period   <= wr_data[15:0];
            default: ;
         endcase
      end
   end

   assign adc_threshold = threshold_ff;
   assign cfg           = cfg_ff;

endmodule

`default_nettype wire

// ----- rtl/tss_core.sv -----
`default_nettype none

module tss_core import tss_pkg::*; #(
   parameter int ADC_WIDTH = 10
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 tick,
   input  wire logic                 hazard_btn_n,
   input  wire logic                 left_btn_n,
   input  wire logic                 right_btn_n,
   input  wire logic [ADC_WIDTH-1:0] light_sample,
   input  wire logic [ADC_WIDTH-1:0] adc_threshold,
   input  wire cfg_type              cfg,
   output result_type                result
);

   logic [7:0]  sample_timer_ff,  sample_timer_in;
   logic [15:0] blink_timer_ff,   blink_timer_in;
   mode_type    last_code_ff,     last_code_in;
   mode_type    selected_mode_ff, selected_mode_in;
   mode_type    previous_mode_ff, previous_mode_in;
   logic [1:0]  step_count_ff,    step_count_in;
   logic        hazard_phase_ff,  hazard_phase_in;
   logic [2:0]  left_lamps_ff,    left_lamps_in;
   logic [2:0]  right_lamps_ff,   right_lamps_in;
   logic [7:0]  duty_value_ff,    duty_value_in;

   always_comb begin
      mode_type   code;
      logic [2:0] lamps;
      logic       seq_due;

      sample_timer_in  = sample_timer_ff + 8'd1;
      blink_timer_in   = blink_timer_ff + 16'd1;
      last_code_in     = last_code_ff;
      selected_mode_in = selected_mode_ff;
      previous_mode_in = previous_mode_ff;
      step_count_in    = step_count_ff;
      hazard_phase_in  = hazard_phase_ff;
      left_lamps_in    = left_lamps_ff;
      right_lamps_in   = right_lamps_ff;
      duty_value_in    = duty_value_ff;
      code             = MODE_IDLE;
      lamps            = 3'd0;

      // equal sample keeps the old duty
      if (light_sample > adc_threshold) begin
         duty_value_in = cfg.duty_high;
      end else if (light_sample < adc_threshold) begin
         duty_value_in = cfg.duty_low;
      end

      if (sample_timer_in > cfg.sample_interval) begin
         sample_timer_in = 8'd0;
         priority if (!hazard_btn_n) begin
            code = MODE_HAZARD;
         end else if (!left_btn_n) begin
            code = MODE_LEFT;
         end else if (!right_btn_n) begin
            code = MODE_RIGHT;
         end else begin
            code = MODE_IDLE;
         end
         if (code != last_code_ff) begin
            last_code_in = code;
            if (code != MODE_IDLE) begin
               selected_mode_in = (code == selected_mode_ff) ? MODE_IDLE : code;
            end
         end
      end

      if (selected_mode_in != previous_mode_ff) begin
         left_lamps_in  = 3'd0;
         right_lamps_in = 3'd0;
      end
      if (selected_mode_in != MODE_IDLE) begin
         previous_mode_in = selected_mode_in;
      end

      seq_due = (blink_timer_in >= cfg.sequence_period);
      unique case (selected_mode_in)
         MODE_HAZARD: begin
            if (blink_timer_in >= cfg.hazard_period) begin
               blink_timer_in  = 16'd0;
               left_lamps_in   = {3{~hazard_phase_ff}};
               right_lamps_in  = {3{~hazard_phase_ff}};
               hazard_phase_in = ~hazard_phase_ff;
            end
         end
         MODE_LEFT, MODE_RIGHT: begin
            if (seq_due) begin
               blink_timer_in = 16'd0;
               lamps = (selected_mode_in == MODE_LEFT) ? left_lamps_in : right_lamps_in;
               // shared step: light one more lamp, then clear on the fourth
               if (step_count_ff != 2'd3) begin
                  lamps         = lamps | (3'd1 << step_count_ff);
                  step_count_in = step_count_ff + 2'd1;
               end else begin
                  lamps         = 3'd0;
                  step_count_in = 2'd0;
               end
               if (selected_mode_in == MODE_LEFT) begin
                  left_lamps_in = lamps;
               end else begin
                  right_lamps_in = lamps;
               end
            end
         end
         MODE_IDLE: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_timer_ff  <= 8'd0;
         blink_timer_ff   <= 16'd0;
         last_code_ff     <= MODE_IDLE;
         selected_mode_ff <= MODE_IDLE;
         previous_mode_ff <= MODE_IDLE;
         step_count_ff    <= 2'd0;
         hazard_phase_ff  <= 1'b0;
         left_lamps_ff    <= 3'd0;
         right_lamps_ff   <= 3'd0;
         duty_value_ff    <= 8'd0;
      end else if (tick) begin
         sample_timer_ff  <= sample_timer_in;
         blink_timer_ff   <= blink_timer_in;
         last_code_ff     <= last_code_in;
         selected_mode_ff <= selected_mode_in;
         previous_mode_ff <= previous_mode_in;
         step_count_ff    <= step_count_in;
         hazard_phase_ff  <= hazard_phase_in;
         left_lamps_ff    <= left_lamps_in;
         right_lamps_ff   <= right_lamps_in;
         duty_value_ff    <= duty_value_in;
      end
   end

   // next outputs, captured by the result register on the same edge
   assign result.left_leds  = left_lamps_in;
   assign result.right_leds = right_lamps_in;
   assign result.pwm_duty   = duty_value_in;

endmodule

`default_nettype wire

// ----- rtl/turn_signal_sequencer.sv -----
// latency: the result of a tick beat is valid in the cycle after the beat is accepted
// throughput: one tick beat per cycle if rsp ready; the result register frees as taken
// the state update and the compares are one pass of logic before the result register
// reset: synchronous, clears core state and lamps, csr registers take their defaults
`default_nettype none

module turn_signal_sequencer import tss_pkg::*; #(
   parameter int ADC_WIDTH = 10
) (
   input  wire logic clock,
   input  wire logic reset,
   tss_req_intf.sink   req_if,
   tss_rsp_intf.source rsp_if,
   tss_csr_intf.sink   csr_if
);

   logic                 req_take;
   logic [ADC_WIDTH-1:0] adc_threshold;
   cfg_type              cfg;
   result_type           result_next;
   result_type           result_ff;
   logic                 rsp_valid_ff;

   assign csr_if.ready = 1'b1;

   tss_csr #(.ADC_WIDTH(ADC_WIDTH)) u_csr (
      .clock         (clock),
      .reset         (reset),
      .wr_en         (csr_if.valid),
      .wr_index      (csr_if.index),
      .wr_data       (csr_if.data),
      .adc_threshold (adc_threshold),
      .cfg           (cfg)
   );

   // a new beat goes in when no result is held or the held result leaves on the same edge
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_take     = req_if.valid && req_if.ready;

   tss_core #(.ADC_WIDTH(ADC_WIDTH)) u_core (
      .clock         (clock),
      .reset         (reset),
      .tick          (req_take),
      .hazard_btn_n  (req_if.hazard_btn_n),
      .left_btn_n    (req_if.left_btn_n),
      .right_btn_n   (req_if.right_btn_n),
      .light_sample  (req_if.light_sample[ADC_WIDTH-1:0]),
      .adc_threshold (adc_threshold),
      .cfg           (cfg),
      .result        (result_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         result_ff <= result_next;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.left_leds  = result_ff.left_leds;
   assign rsp_if.right_leds = result_ff.right_leds;
   assign rsp_if.pwm_duty   = result_ff.pwm_duty;

endmodule

`default_nettype wire
